// File: hw/rtl/ray_cube_entry_face_macros.svh
// Assertion helpers; clk and arst_n must exist in the using module.
`ifndef RAY_CUBE_ENTRY_FACE_MACROS_SVH
`define RAY_CUBE_ENTRY_FACE_MACROS_SVH

// Same-cycle implication.
`define RCEF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed (same cycle)");

// Next-cycle implication.
`define RCEF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed (next cycle)");

`endif

// File: hw/rtl/rcef_pkg.sv
`timescale 1ns / 1ps
package rcef_pkg;

	localparam int POS_W      = 32;
	localparam int DIR_W      = 16;
	localparam int CELL_W     = 16;
	localparam int FACE_W     = 3;
	localparam int DIFF_W     = 34;
	localparam int NUM_W      = 48;
	localparam int DEN_W      = 16;
	localparam int REM_W      = DEN_W + 1;
	localparam int T_W        = 48;
	localparam int PROD_W     = DIR_W + T_W;
	localparam int COORD_W    = 50;
	localparam int DIV_BPS    = 4;
	localparam int DIV_STAGES = NUM_W / DIV_BPS;

	// internal face numbering
	typedef enum logic [FACE_W-1:0] {
		FACE_PY = 3'd0,
		FACE_NY = 3'd1,
		FACE_PZ = 3'd2,
		FACE_PX = 3'd3,
		FACE_NZ = 3'd4,
		FACE_NX = 3'd5
	} face_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] nq;   // numerator bits shift out, quotient bits shift in
	} div_st_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0]  origin;
		logic [2:0][DIR_W-1:0]  dir;
		logic [2:0][CELL_W-1:0] ctr;
		logic [2:0]             qneg;
	} meta_t;

	// DIV_BPS restoring steps
	function automatic div_st_t div_step(div_st_t cur, logic [DEN_W-1:0] den);
		div_st_t          st;
		logic [REM_W-1:0] r;
		st = cur;
		for (int k = 0; k < DIV_BPS; k++) begin
			r     = {st.rem[REM_W-2:0], st.nq[NUM_W-1]};
			st.nq = {st.nq[NUM_W-2:0], 1'b0};
			if (r >= {1'b0, den}) begin
				r        = r - {1'b0, den};
				st.nq[0] = 1'b1;
			end
			st.rem = r;
		end
		return st;
	endfunction

	// face hit on axis a (0 x, 1 y, 2 z)
	function automatic face_t axis_face(int a, logic neg);
		face_t f;
		case (a)
			0:       f = neg ? FACE_PX : FACE_NX;
			1:       f = neg ? FACE_PY : FACE_NY;
			default: f = neg ? FACE_PZ : FACE_NZ;
		endcase
		return f;
	endfunction

	// cell + step, clamped to the signed 16-bit range
	function automatic logic [CELL_W-1:0] sat_step(logic [CELL_W-1:0] c, logic [1:0] n);
		logic [CELL_W:0] s;
		s = {c[CELL_W-1], c} + {{(CELL_W-1){n[1]}}, n};
		if (s[CELL_W] != s[CELL_W-1])
			return s[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
		return s[CELL_W-1:0];
	endfunction

endpackage

// File: hw/rtl/rcef_div.sv
`timescale 1ns / 1ps
module rcef_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rcef_pkg::NUM_W-1:0]  num,
	input  logic [rcef_pkg::DEN_W-1:0]  den,
	output logic [rcef_pkg::NUM_W-1:0]  quo
);
	import rcef_pkg::*;

	div_st_t          st_s  [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0]  <= div_step('{rem: '0, nq: num}, den);
			den_s[0] <= den;
			for (int i = 1; i < DIV_STAGES; i++)
				st_s[i] <= div_step(st_s[i-1], den_s[i-1]);
			for (int i = 1; i < DIV_STAGES - 1; i++)
				den_s[i] <= den_s[i-1];
		end
	end

	assign quo = st_s[DIV_STAGES-1].nq;

endmodule

// File: hw/rtl/ray_cube_entry_face.sv
// Ray / unit-cube entry face, fully pipelined.
// Input channel (in_valid/in_ready): ray origin (Q16.16), direction (Q1.15)
// and integer cube centre. Output channel (out_valid/out_ready): entered
// face code (3 and 5 swapped) and the neighbouring cell behind that face.
// Throughput: one request per cycle unless the receiver stalls. A request
// passes 17 register stages from the accepting edge to out_valid: 1 setup,
// 12 divider (4 quotient bits each), saturate, multiply, coordinate test, output.
// The divider depth (48 quotient bits, 4 per stage) sets the latency.
// Reset (arst_n low) clears all valid bits; no request is in flight after.
// When the receiver stalls, the whole pipe freezes (in_ready drops) while
// the output register holds its request; no request is lost or repeated.
`timescale 1ns / 1ps
`include "ray_cube_entry_face_macros.svh"
module ray_cube_entry_face (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [rcef_pkg::POS_W-1:0]  origin_x,
	input  logic signed [rcef_pkg::POS_W-1:0]  origin_y,
	input  logic signed [rcef_pkg::POS_W-1:0]  origin_z,
	input  logic signed [rcef_pkg::DIR_W-1:0]  dir_x,
	input  logic signed [rcef_pkg::DIR_W-1:0]  dir_y,
	input  logic signed [rcef_pkg::DIR_W-1:0]  dir_z,
	input  logic signed [rcef_pkg::CELL_W-1:0] cell_x,
	input  logic signed [rcef_pkg::CELL_W-1:0] cell_y,
	input  logic signed [rcef_pkg::CELL_W-1:0] cell_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rcef_pkg::FACE_W-1:0]        face_code,
	output logic signed [rcef_pkg::CELL_W-1:0] place_x,
	output logic signed [rcef_pkg::CELL_W-1:0] place_y,
	output logic signed [rcef_pkg::CELL_W-1:0] place_z
);
	import rcef_pkg::*;

	// global advance: the pipe moves whenever the output slot is free or drains
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: plane offset and divider operands ----------------
	meta_t                 meta_in;
	logic [2:0][NUM_W-1:0] num_in;
	logic [2:0][DEN_W-1:0] den_in;
	logic [2:0]            qneg_in;

	always_comb begin
		logic signed [POS_W:0]    plane;
		logic signed [DIFF_W-1:0] diff;
		logic [DIFF_W-1:0]        mag;
		logic                     dneg;
		meta_in.origin = {origin_z, origin_y, origin_x};
		meta_in.dir    = {dir_z, dir_y, dir_x};
		meta_in.ctr    = {cell_z, cell_y, cell_x};
		for (int a = 0; a < 3; a++) begin
			dneg  = meta_in.dir[a][DIR_W-1];
			plane = $signed({meta_in.ctr[a][CELL_W-1], meta_in.ctr[a], 16'b0});
			plane = dneg ? plane + 33'sd32768 : plane - 33'sd32768;
			diff  = $signed({plane[POS_W], plane})
				- $signed({{2{meta_in.origin[a][POS_W-1]}}, meta_in.origin[a]});
			mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
			num_in[a]  = {mag[DIFF_W-2:0], 15'b0};
			den_in[a]  = dneg ? DEN_W'(-meta_in.dir[a]) : meta_in.dir[a];
			qneg_in[a] = diff[DIFF_W-1] ^ dneg;
		end
		meta_in.qneg = qneg_in;
	end

	logic                  vld_s1;
	meta_t                 meta_s1;
	logic [2:0][NUM_W-1:0] num_s1;
	logic [2:0][DEN_W-1:0] den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_in;
			num_s1  <= num_in;
			den_s1  <= den_in;
		end
	end

	// ---------------- divider stages ----------------
	logic [2:0][NUM_W-1:0] quo;

	for (genvar g = 0; g < 3; g++) begin : g_div
		rcef_div u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s1[g]),
			.den (den_s1[g]),
			.quo (quo[g])
		);
	end

	logic  vld_d  [DIV_STAGES];
	meta_t meta_d [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++)
				vld_d[i] <= 1'b0;
		end else if (adv) begin
			vld_d[0] <= vld_s1;
			for (int i = 1; i < DIV_STAGES; i++)
				vld_d[i] <= vld_d[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_d[0] <= meta_s1;
			for (int i = 1; i < DIV_STAGES; i++)
				meta_d[i] <= meta_d[i-1];
		end
	end

	// ---------------- stage 2: signed t with saturation ----------------
	meta_t               meta_last;
	logic [2:0][T_W-1:0] t_c;
	assign meta_last = meta_d[DIV_STAGES-1];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (meta_last.qneg[a])
				t_c[a] = (quo[a] > {1'b1, {(T_W-1){1'b0}}})
					? {1'b1, {(T_W-1){1'b0}}} : T_W'(-quo[a]);
			else
				t_c[a] = quo[a][T_W-1] ? {1'b0, {(T_W-1){1'b1}}} : quo[a];
		end
	end

	logic                vld_s2;
	meta_t               meta_s2;
	logic [2:0][T_W-1:0] t_s2;

	// ---------------- stage 3: dir * t for the two cross axes ----------------
	logic [2:0][1:0][PROD_W-1:0] prod_c;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod_c[a][0] = PROD_W'($signed(meta_s2.dir[(a+1)%3]))
				* PROD_W'($signed(t_s2[a]));
			prod_c[a][1] = PROD_W'($signed(meta_s2.dir[(a+2)%3]))
				* PROD_W'($signed(t_s2[a]));
		end
	end

	logic                        vld_s3;
	meta_t                       meta_s3;
	logic [2:0][1:0][PROD_W-1:0] prod_s3;

	// ---------------- stage 4: coordinate at t, face bounds ----------------
	logic [2:0] pass_c;

	always_comb begin
		logic signed [PROD_W-1:0]  p;
		logic signed [PROD_W-1:0]  sh;
		logic signed [COORD_W-1:0] coord;
		logic signed [COORD_W-1:0] cen;
		logic                      ok;
		int                        ax;
		for (int a = 0; a < 3; a++) begin
			ok = (meta_s3.dir[a] != '0);
			for (int k = 0; k < 2; k++) begin
				ax    = (a + 1 + k) % 3;
				p     = $signed(prod_s3[a][k]);
				// divide by 2^15, truncating toward zero
				sh    = (p + (p[PROD_W-1] ? 64'sd32767 : 64'sd0)) >>> 15;
				coord = $signed(sh[COORD_W-1:0])
					+ COORD_W'($signed(meta_s3.origin[ax]));
				cen   = COORD_W'($signed({meta_s3.ctr[ax], 16'b0}));
				ok    = ok && (coord >= cen - 50'sd32768) && (coord <= cen + 50'sd32768);
			end
			pass_c[a] = ok;
		end
	end

	logic       vld_s4;
	meta_t      meta_s4;
	logic [2:0] pass_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_d[DIV_STAGES-1];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_last;
			t_s2    <= t_c;
			meta_s3 <= meta_s2;
			prod_s3 <= prod_c;
			meta_s4 <= meta_s3;
			pass_s4 <= pass_c;
		end
	end

	// ---------------- output stage: pick face, step cell ----------------
	face_t                  face_c;
	logic [FACE_W-1:0]      code_c;
	logic [2:0][1:0]        nrm_c;
	logic [2:0][CELL_W-1:0] place_c;

	always_comb begin
		face_c = FACE_PY;
		// later axes override earlier ones
		for (int a = 0; a < 3; a++)
			if (pass_s4[a])
				face_c = axis_face(a, meta_s4.dir[a][DIR_W-1]);
		nrm_c = '0;
		unique case (face_c)
			FACE_PY: nrm_c[1] = 2'b01;
			FACE_NY: nrm_c[1] = 2'b11;
			FACE_PZ: nrm_c[2] = 2'b01;
			FACE_PX: nrm_c[0] = 2'b01;
			FACE_NZ: nrm_c[2] = 2'b11;
			FACE_NX: nrm_c[0] = 2'b11;
			default: nrm_c    = '0;
		endcase
		// reported code swaps +x and -x
		case (face_c)
			FACE_PX: code_c = FACE_NX;
			FACE_NX: code_c = FACE_PX;
			default: code_c = face_c;
		endcase
		for (int i = 0; i < 3; i++)
			place_c[i] = sat_step(meta_s4.ctr[i], nrm_c[i]);
	end

	logic                   vld_q;
	logic [FACE_W-1:0]      code_q;
	logic [2:0][CELL_W-1:0] place_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_q  <= code_c;
			place_q <= place_c;
		end
	end

	assign out_valid = vld_q;
	assign face_code = code_q;
	assign place_x   = place_q[0];
	assign place_y   = place_q[1];
	assign place_z   = place_q[2];

	// ---------------- checks ----------------
	`RCEF_ASSERT_NOW(a_code_range, out_valid, (face_code != 3'd6) && (face_code != 3'd7))
	`RCEF_ASSERT_NEXT(a_tail_moves, vld_s4 && adv, out_valid)
	`RCEF_ASSERT_NEXT(a_stall_holds, !adv, vld_s4 == $past(vld_s4))
	`RCEF_ASSERT_NEXT(a_head_moves, in_valid && in_ready, vld_s1)

endmodule

// File: test/tb_ray_cube_entry_face.sv
`timescale 1ns / 1ps
module tb_ray_cube_entry_face;
	import rcef_pkg::*;

	localparam longint T_HI = 64'sd140737488355327;
	localparam longint T_LO = -64'sd140737488355328;
	localparam longint HALF = 64'sd32768;
	localparam int N_RANDOM = 1250;
	localparam int N_ROWS   = 18;

	// one request as the predictor and the stimulus see it
	typedef struct {
		logic signed [POS_W-1:0]  org [3];
		logic signed [DIR_W-1:0]  dir [3];
		logic signed [CELL_W-1:0] cel [3];
	} ray_req_t;

	typedef struct {
		logic [FACE_W-1:0]        face;
		logic signed [CELL_W-1:0] place [3];
	} hit_t;

	// directed row: request plus optional typed-in answer
	typedef struct {
		ray_req_t req;
		bit       fixed;
		hit_t     ans;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [POS_W-1:0]  origin_x, origin_y, origin_z;
	logic signed [DIR_W-1:0]  dir_x, dir_y, dir_z;
	logic signed [CELL_W-1:0] cell_x, cell_y, cell_z;
	logic [FACE_W-1:0]        face_code;
	logic signed [CELL_W-1:0] place_x, place_y, place_z;

	hit_t   exp_hits [N_ROWS + N_RANDOM];
	int     n_sent;
	int     n_seen;
	int     mismatches;

	ray_cube_entry_face u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	// signed divide truncating toward zero (SV already does this for longint)
	function automatic hit_t entry_face(ray_req_t r);
		longint p[3], d[3], c[3];
		longint plane, t, cb, cc;
		int     b, cx, a, i;
		face_t  f;
		hit_t   h;
		longint q;
		f = FACE_PY;
		for (i = 0; i < 3; i++) begin
			p[i] = r.org[i];
			d[i] = r.dir[i];
			c[i] = longint'(r.cel[i]) * 65536;
		end
		for (a = 0; a < 3; a++) begin
			b  = (a + 1) % 3;
			cx = (a + 2) % 3;
			if (d[a] == 0) continue;
			plane = d[a] < 0 ? c[a] + HALF : c[a] - HALF;
			t = ((plane - p[a]) * 32768) / d[a];
			if (t > T_HI) t = T_HI;
			if (t < T_LO) t = T_LO;
			cb = p[b] + (d[b] * t) / 32768;
			cc = p[cx] + (d[cx] * t) / 32768;
			if (cb >= c[b] - HALF && cb <= c[b] + HALF &&
					cc >= c[cx] - HALF && cc <= c[cx] + HALF) begin
				case (a)
					0: f = d[a] < 0 ? FACE_PX : FACE_NX;
					1: f = d[a] < 0 ? FACE_PY : FACE_NY;
					default: f = d[a] < 0 ? FACE_PZ : FACE_NZ;
				endcase
			end
		end
		h.face = (f == FACE_PX) ? FACE_NX : (f == FACE_NX) ? FACE_PX : f;
		for (i = 0; i < 3; i++) begin
			q = longint'(r.cel[i]);
			case (f)
				FACE_PY: if (i == 1) q++;
				FACE_NY: if (i == 1) q--;
				FACE_PZ: if (i == 2) q++;
				FACE_NZ: if (i == 2) q--;
				FACE_PX: if (i == 0) q++;
				default: if (i == 0) q--;
			endcase
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			h.place[i] = q[15:0];
		end
		return h;
	endfunction

	function automatic ray_req_t mk(longint ox, longint oy, longint oz,
			int dx, int dy, int dz, int cx, int cy, int cz);
		ray_req_t r;
		r.org[0] = 32'(ox); r.org[1] = 32'(oy); r.org[2] = 32'(oz);
		r.dir[0] = 16'(dx); r.dir[1] = 16'(dy); r.dir[2] = 16'(dz);
		r.cel[0] = 16'(cx); r.cel[1] = 16'(cy); r.cel[2] = 16'(cz);
		return r;
	endfunction

	function automatic hit_t mkh(int f, int x, int y, int z);
		hit_t h;
		h.face = 3'(f);
		h.place[0] = 16'(x); h.place[1] = 16'(y); h.place[2] = 16'(z);
		return h;
	endfunction

	// random ray, mostly aimed near the cell so faces get hit
	function automatic ray_req_t rand_req();
		ray_req_t r;
		int i, mode;
		mode = $urandom_range(0, 9);
		for (i = 0; i < 3; i++) begin
			if (mode < 7) begin
				r.cel[i] = 16'($urandom_range(0, 15) - 8);
				r.org[i] = 32'(longint'(r.cel[i]) * 65536 + $urandom_range(0, 5 * 65536)
					- 5 * 32768);
				r.dir[i] = $urandom_range(0, 7) == 0 ? 16'sd0 : 16'($urandom);
			end else begin
				r.cel[i] = 16'($urandom);
				r.org[i] = 32'($urandom);
				r.dir[i] = $urandom_range(0, 3) == 0 ? 16'sd0 : 16'($urandom);
			end
		end
		return r;
	endfunction

	task automatic send_req(ray_req_t r);
		int gap;
		origin_x <= r.org[0]; origin_y <= r.org[1]; origin_z <= r.org[2];
		dir_x <= r.dir[0]; dir_y <= r.dir[1]; dir_z <= r.dir[2];
		cell_x <= r.cel[0]; cell_y <= r.cel[1]; cell_z <= r.cel[2];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		// burst: mostly keep valid up; sometimes drop for a random gap
		if ($urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// receiver: stall pattern of its own
	initial begin
		int k;
		out_ready = 1'b0;
		@(posedge arst_n);
		k = 0;
		forever begin
			@(posedge clk);
			k++;
			if ((k / 200) % 3 == 2) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// output checker, samples on the edge where the request is accepted
	always @(posedge clk) begin
		hit_t e;
		if (arst_n && out_valid && out_ready) begin
			if (n_seen >= n_sent) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result face %0d", face_code);
			end else begin
				e = exp_hits[n_seen];
				n_seen++;
				if (e.face !== face_code || e.place[0] !== place_x ||
						e.place[1] !== place_y || e.place[2] !== place_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d (%0d,%0d,%0d) got %0d (%0d,%0d,%0d)",
							e.face, e.place[0], e.place[1], e.place[2],
							face_code, place_x, place_y, place_z);
				end
			end
		end
	end

	initial begin
		row_t     rows [N_ROWS];
		row_t     rw;
		ray_req_t r;
		hit_t     h;
		int       n, i, nr;
		in_valid = 1'b0;
		origin_x = '0; origin_y = '0; origin_z = '0;
		dir_x = '0; dir_y = '0; dir_z = '0;
		cell_x = '0; cell_y = '0; cell_z = '0;
		mismatches = 0;
		n_sent = 0;
		n_seen = 0;
		nr = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all zero direction: no axis, face +y
		rw.req = mk(0, 0, 0, 0, 0, 0, 0, 0, 0); rw.fixed = 1; rw.ans = mkh(0, 0, 1, 0);
		rows[nr] = rw; nr++;
		// top cell with zero direction: y saturates
		rw.req = mk(0, 0, 0, 0, 0, 0, 32767, 32767, 32767); rw.fixed = 1;
		rw.ans = mkh(0, 32767, 32767, 32767);
		rows[nr] = rw; nr++;
		// straight down +x from the left: enters -x face, code swapped
		rw.req = mk(-3 * 65536, 0, 0, 32767, 0, 0, 0, 0, 0); rw.fixed = 1;
		rw.ans = mkh(3, -1, 0, 0);
		rows[nr] = rw; nr++;
		// going -x from the right: +x face
		rw.req = mk(3 * 65536, 0, 0, -32768, 0, 0, 0, 0, 0); rw.fixed = 1;
		rw.ans = mkh(5, 1, 0, 0);
		rows[nr] = rw; nr++;
		// bottom cell, -x neighbour saturates
		rw.req = mk(-32'sd2147483648, 0, 0, 32767, 0, 0, -32768, 0, 0); rw.fixed = 0;
		rows[nr] = rw; nr++;
		// y and z axes both ways
		rw.req = mk(0, 3 * 65536, 0, 0, -32768, 0, 0, 0, 0); rw.fixed = 1;
		rw.ans = mkh(0, 0, 1, 0);
		rows[nr] = rw; nr++;
		rw.req = mk(0, -3 * 65536, 0, 0, 32767, 0, 0, 0, 0); rw.fixed = 1;
		rw.ans = mkh(1, 0, -1, 0);
		rows[nr] = rw; nr++;
		rw.req = mk(0, 0, 3 * 65536, 0, 0, -32768, 0, 0, 0); rw.fixed = 1;
		rw.ans = mkh(2, 0, 0, 1);
		rows[nr] = rw; nr++;
		rw.req = mk(0, 0, -3 * 65536, 0, 0, 32767, 0, 0, 0); rw.fixed = 1;
		rw.ans = mkh(4, 0, 0, -1);
		rows[nr] = rw; nr++;
		// extremes, plane behind origin, huge t, diagonals
		rw.fixed = 0;
		rw.req = mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32767, 32767, 32767,
			-32768, -32768, -32768);
		rows[nr] = rw; nr++;
		rw.req = mk(-32'sd2147483648, -32'sd2147483648, -32'sd2147483648, -32768, -32768,
			-32768, 32767, 32767, 32767);
		rows[nr] = rw; nr++;
		rw.req = mk(0, 0, 0, 1, 1, 1, 0, 0, 0);
		rows[nr] = rw; nr++;
		rw.req = mk(0, 0, 0, -1, -1, -1, 5, 5, 5);
		rows[nr] = rw; nr++;
		rw.req = mk(3 * 65536, 0, 0, 32767, 0, 0, 0, 0, 0);
		rows[nr] = rw; nr++;
		rw.req = mk(-65536, -65536, -65536, 18918, 18918, 18918, 0, 0, 0);
		rows[nr] = rw; nr++;
		rw.req = mk(-65536, 32768, 0, 32767, 0, 0, 0, 0, 0);
		rows[nr] = rw; nr++;
		rw.req = mk(-65536, 32769, 0, 32767, 0, 0, 0, 0, 0);
		rows[nr] = rw; nr++;
		rw.req = mk(32'sh7fffffff, 0, 0, 1, 0, 0, -32768, 0, 0);
		rows[nr] = rw; nr++;

		for (i = 0; i < nr; i++) begin
			h = entry_face(rows[i].req);
			if (rows[i].fixed) h = rows[i].ans;
			exp_hits[n_sent] = h;
			n_sent++;
			send_req(rows[i].req);
		end
		for (n = 0; n < N_RANDOM; n++) begin
			r = rand_req();
			exp_hits[n_sent] = entry_face(r);
			n_sent++;
			send_req(r);
		end
		in_valid <= 1'b0;
		while (n_seen < n_sent) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
